/* rtl/wavelet_luma_sharpener_defines.svh */
// Assertion macros for the wavelet luma sharpener.
`ifndef WAVELET_LUMA_SHARPENER_DEFINES_SVH
`define WAVELET_LUMA_SHARPENER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WLS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/wls_pkg.sv */
// Shared types, constants and saturation helpers of the wavelet luma sharpener.
`timescale 1ns / 1ps
`default_nettype none
package wls_pkg;

	typedef logic signed [23:0] sample_t;
	typedef logic [11:0]        coord_t;
	typedef logic [1:0]         plane_t;
	typedef logic [12:0]        gain_t;

	typedef struct packed {
		coord_t lo;
		coord_t hi;
	} nbr_t;

	localparam plane_t PLANE_ACC = 2'd0;
	localparam plane_t PLANE_A   = 2'd1;
	localparam plane_t PLANE_B   = 2'd2;
	localparam plane_t PLANE_SCR = 2'd3;

	localparam int CFG_DATA_W = 39;
	localparam logic [2:0] CFG_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_LEVELS = 3'd2;
	localparam logic [2:0] CFG_CUTOFF = 3'd3;
	localparam logic [2:0] CFG_GAIN_L = 3'd4;
	localparam logic [2:0] CFG_GAIN_H = 3'd5;
	localparam logic [2:0] CFG_RANGE  = 3'd6;

	localparam gain_t GAIN_UNITY = 13'd256;
	localparam logic signed [15:0] LIM_LO_LTD  = 16'sd16;
	localparam logic signed [15:0] LIM_HI_LTD  = 16'sd235;
	localparam logic signed [15:0] LIM_LO_FULL = 16'sd0;
	localparam logic signed [15:0] LIM_HI_FULL = 16'sd255;

	localparam logic signed [47:0] S24_MAX = 48'sd8388607;
	localparam logic signed [47:0] S24_MIN = -48'sd8388608;

	function automatic sample_t sat24(input logic signed [47:0] v);
		sample_t r;
		if (v > S24_MAX)
			r = 24'sh7FFFFF;
		else if (v < S24_MIN)
			r = 24'sh800000;
		else
			r = v[23:0];
		return r;
	endfunction

	// Mirrored neighbours at distance d of position k on a line of n.
	function automatic nbr_t nbr(input coord_t k, input coord_t n, input coord_t d);
		nbr_t r;
		if (k < d) begin
			r.lo = d - k;
			r.hi = k + d;
		end else if (k + d < n) begin
			r.lo = k - d;
			r.hi = k + d;
		end else begin
			r.lo = k - d;
			r.hi = (n << 1) - 12'd2 - (k + d);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/wls_if.sv */
// Request and result channel interfaces of the wavelet luma sharpener.
`timescale 1ns / 1ps
`default_nettype none
interface wls_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_pixel;
	modport source (output valid, output req_type, output in_pixel, input ready);
	modport sink   (input valid, input req_type, input in_pixel, output ready);
endinterface

interface wls_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_pixel;
	logic       last_of_frame;
	modport source (output valid, output out_pixel, output last_of_frame, input ready);
	modport sink   (input valid, input out_pixel, input last_of_frame, output ready);
endinterface
`default_nettype wire

/* rtl/wls_plane_mem.sv */
// One sample plane: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none
module wls_plane_mem #(
	parameter int DEPTH = 1048576,
	parameter int AW    = 20
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire wls_pkg::sample_t wdata,
	input  wire logic [AW-1:0]    raddr,
	output wls_pkg::sample_t      rdata
);

	wls_pkg::sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/wavelet_luma_sharpener.sv */
// Top level: frame loader, a-trous hat wavelet sequencer and result drain.
// Use: req carries transfers of req_type/in_pixel. req_type 0 loads the next
// luma sample in raster order; the transfer that completes a frame of
// frame_width x frame_height starts processing, during which req.ready is low.
// req_type 1 drains the next sharpened sample: the read transfer sets a pending
// flag, then one result appears on rsp and is held in an output register until
// rsp.ready takes it. A new read is taken only once that register is empty and
// no read is pending, so no new read is taken before rsp has the last result.
// Reads while loading and writes while draining are taken and dropped.
// Processing: per level, a horizontal pass, a vertical pass and a detail pass,
// each reading the samples of a pixel one after another through the single
// read port of each plane memory, then, if any level ran, a pass adding the
// final lowpass back. Loading takes one pixel per cycle while req.valid is high.
// Reset clears positions and state, presets the config; the four plane memories
// are not cleared and need no clearing pass, as every entry read is written
// first. A stalled rsp only holds the drain; configuration writes land at once.
`timescale 1ns / 1ps
`default_nettype none
`include "wavelet_luma_sharpener_defines.svh"
module wavelet_luma_sharpener #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_LEVELS = 5
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [wls_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	wls_req_if.sink                              req,
	wls_pix_if.source                            rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AB    = $clog2(DEPTH);
	localparam int PB    = $clog2(DEPTH + 1);
	localparam int LB    = $clog2(MAX_LEVELS + 1);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_LEVEL = 3'd1;
	localparam logic [2:0] ST_HOR   = 3'd2;
	localparam logic [2:0] ST_VER   = 3'd3;
	localparam logic [2:0] ST_DET   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;

	// configuration
	logic [10:0] fw_q, fh_q;
	logic [2:0]  lc_q;
	logic [9:0]  cut_q;
	logic [38:0] gl_q;
	logic [25:0] gh_q;
	logic        lim_q;

	// sequencer state
	logic [2:0]       st_q;
	logic [1:0]       ph_q;
	logic [PB-1:0]    wp_q, rp_q, size_q;
	wls_pkg::coord_t  w_q, h_q, mind_q, r_q, c_q;
	logic [LB-1:0]    lvls_q, lev_q;
	wls_pkg::plane_t  hp_q, lp_q;
	logic             ran_q;
	logic [AB-1:0]    base_q, idx_q, mul_q;
	logic signed [26:0] sum_q;
	logic signed [24:0] det_q;
	logic signed [38:0] prod_q;
	logic             big_q;
	wls_pkg::sample_t nsrc_q;
	logic             pend_q;
	logic             out_v_q;
	logic [7:0]       out_pix_q;
	logic             out_last_q;

	// memory ports
	logic             wr_en;
	wls_pkg::plane_t  wr_sel;
	logic [AB-1:0]    wr_addr;
	wls_pkg::sample_t wr_data;
	logic [AB-1:0]    rd_addr;
	wls_pkg::sample_t rdata [4];

	// derived values
	wls_pkg::coord_t  ew, eh, dil;
	logic [23:0]      size_full;
	logic [PB-1:0]    size_live, wp_nxt;
	wls_pkg::nbr_t    nc, nr;
	wls_pkg::gain_t   gain;
	wls_pkg::sample_t x_src, x_dst, x_scr, x_acc;
	logic signed [26:0] x27, sum_end;
	logic signed [24:0] det_c, mag_c;
	logic signed [38:0] prod_sh;
	wls_pkg::sample_t nsrc_c;
	logic signed [15:0] drain_v, lim_lo, lim_hi;
	logic [7:0]       drain_pix;
	logic             acc_in, in_ready, idx_last, col_last, row_last;

	for (genvar p = 0; p < 4; p++) begin : g_plane
		wls_plane_mem #(.DEPTH(DEPTH), .AW(AB)) u_mem (
			.clk   (clk),
			.we    (wr_en && (wr_sel == wls_pkg::plane_t'(p))),
			.waddr (wr_addr),
			.wdata (wr_data),
			.raddr (rd_addr),
			.rdata (rdata[p])
		);
	end

	assign in_ready  = (st_q == ST_LOAD) || ((st_q == ST_DRAIN) && !pend_q && !out_v_q);
	assign req.ready = in_ready;
	assign acc_in    = req.valid && in_ready;

	assign rsp.valid         = out_v_q;
	assign rsp.out_pixel     = out_pix_q;
	assign rsp.last_of_frame = out_last_q;

	// effective frame size: zero reads as one, larger values saturate to the memory geometry
	always_comb begin
		if (fw_q == 11'd0)
			ew = 12'd1;
		else if (fw_q > MAX_WIDTH)
			ew = wls_pkg::coord_t'(MAX_WIDTH);
		else
			ew = {1'b0, fw_q};
		if (fh_q == 11'd0)
			eh = 12'd1;
		else if (fh_q > MAX_HEIGHT)
			eh = wls_pkg::coord_t'(MAX_HEIGHT);
		else
			eh = {1'b0, fh_q};
	end

	assign size_full = 24'(ew) * 24'(eh);
	assign size_live = PB'(size_full);
	assign wp_nxt    = (wp_q < size_live) ? wp_q + 1'b1 : wp_q;

	assign dil = wls_pkg::coord_t'(1) << lev_q;
	assign nc  = wls_pkg::nbr(c_q, w_q, dil);
	assign nr  = wls_pkg::nbr(r_q, h_q, dil);

	// gains are Q8; levels past the registers run at unity
	always_comb begin
		priority if (lev_q == LB'(0)) gain = gl_q[12:0];
		else if (lev_q == LB'(1))     gain = gl_q[25:13];
		else if (lev_q == LB'(2))     gain = gl_q[38:26];
		else if (lev_q == LB'(3))     gain = gh_q[12:0];
		else if (lev_q == LB'(4))     gain = gh_q[25:13];
		else                          gain = wls_pkg::GAIN_UNITY;
	end

	assign x_src   = rdata[hp_q];
	assign x_dst   = rdata[lp_q];
	assign x_scr   = rdata[wls_pkg::PLANE_SCR];
	assign x_acc   = rdata[wls_pkg::PLANE_ACC];
	assign x27     = {{3{x_src[23]}}, x_src};
	assign sum_end = sum_q + ((st_q == ST_VER) ? {{3{x_dst[23]}}, x_dst} : x27);

	assign det_c   = {x_src[23], x_src} - {x_scr[23], x_scr};
	assign mag_c   = det_c[24] ? -det_c : det_c;
	assign prod_sh = prod_q >>> 8;
	assign nsrc_c  = big_q ? wls_pkg::sat24({{9{prod_sh[38]}}, prod_sh})
	                       : wls_pkg::sat24({{23{det_q[24]}}, det_q});

	assign idx_last = (PB'(idx_q) + 1'b1) == size_q;
	assign col_last = c_q == w_q - 12'd1;
	assign row_last = r_q == h_q - 12'd1;

	// drain: floor divide by 256, then clamp to the selected range
	always_comb begin
		drain_v = x_acc[23:8];
		lim_lo  = lim_q ? wls_pkg::LIM_LO_LTD : wls_pkg::LIM_LO_FULL;
		lim_hi  = lim_q ? wls_pkg::LIM_HI_LTD : wls_pkg::LIM_HI_FULL;
		if (drain_v < lim_lo)
			drain_pix = lim_lo[7:0];
		else if (drain_v > lim_hi)
			drain_pix = lim_hi[7:0];
		else
			drain_pix = drain_v[7:0];
	end

	// read address: centre first, then the two neighbours in the filter passes; else an index
	always_comb begin
		unique case (st_q)
			ST_HOR: begin
				unique case (ph_q)
					2'd0:    rd_addr = base_q + AB'(c_q);
					2'd1:    rd_addr = base_q + AB'(nc.lo);
					default: rd_addr = base_q + AB'(nc.hi);
				endcase
			end
			ST_VER:          rd_addr = (ph_q == 2'd0) ? base_q + AB'(c_q) : mul_q + AB'(c_q);
			ST_DET, ST_FIN:  rd_addr = idx_q;
			default:         rd_addr = rp_q[AB-1:0];
		endcase
	end

	// single write per cycle across all planes
	always_comb begin
		wr_en   = 1'b0;
		wr_sel  = wls_pkg::PLANE_ACC;
		wr_addr = idx_q;
		wr_data = x_scr;
		unique case (st_q)
			ST_LOAD: begin
				wr_en   = acc_in && !req.req_type && (wp_q < size_live);
				wr_addr = wp_q[AB-1:0];
				wr_data = {8'd0, req.in_pixel, 8'd0};
			end
			ST_HOR: begin
				wr_en   = ph_q == 2'd3;
				wr_sel  = lp_q;
				wr_addr = base_q + AB'(c_q);
				wr_data = wls_pkg::sat24({{21{sum_end[26]}}, sum_end});
			end
			ST_VER: begin
				wr_en   = ph_q == 2'd3;
				wr_sel  = wls_pkg::PLANE_SCR;
				wr_addr = base_q + AB'(c_q);
				wr_data = wls_pkg::sat24({{21{sum_end[26]}}, sum_end >>> 4});
			end
			ST_DET: begin
				unique case (ph_q)
					2'd1: begin
						wr_en  = 1'b1;
						wr_sel = lp_q;
						wr_data = x_scr;
					end
					2'd2: begin
						wr_en   = 1'b1;
						wr_sel  = hp_q;
						wr_data = nsrc_c;
					end
					2'd3: begin
						wr_en   = hp_q != wls_pkg::PLANE_ACC;
						wr_data = wls_pkg::sat24(48'(signed'({x_acc[23], x_acc}
						          + {nsrc_q[23], nsrc_q})));
					end
					default: wr_en = 1'b0;
				endcase
			end
			ST_FIN: begin
				wr_en   = ph_q == 2'd1;
				wr_data = wls_pkg::sat24(48'(signed'({x_acc[23], x_acc}
				          + {x_dst[23], x_dst})));
			end
			default: wr_en = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= 11'd1024;
			fh_q  <= 11'd1024;
			lc_q  <= 3'd3;
			cut_q <= 10'd0;
			gl_q  <= 39'd17182066592;
			gh_q  <= 26'd2097408;
			lim_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wls_pkg::CFG_WIDTH:  fw_q  <= cfg_wdata[10:0];
				wls_pkg::CFG_HEIGHT: fh_q  <= cfg_wdata[10:0];
				wls_pkg::CFG_LEVELS: lc_q  <= cfg_wdata[2:0];
				wls_pkg::CFG_CUTOFF: cut_q <= cfg_wdata[9:0];
				wls_pkg::CFG_GAIN_L: gl_q  <= cfg_wdata[38:0];
				wls_pkg::CFG_GAIN_H: gh_q  <= cfg_wdata[25:0];
				wls_pkg::CFG_RANGE:  lim_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_HOR: begin
				if (ph_q == 2'd1)
					sum_q <= x27 <<< 1;
				else if (ph_q == 2'd2)
					sum_q <= sum_q + x27;
			end
			ST_VER: begin
				if (ph_q == 2'd0)
					mul_q <= AB'(24'(nr.lo) * 24'(w_q));
				else if (ph_q == 2'd1) begin
					mul_q <= AB'(24'(nr.hi) * 24'(w_q));
					sum_q <= {{3{x_dst[23]}}, x_dst} <<< 1;
				end else if (ph_q == 2'd2)
					sum_q <= sum_q + {{3{x_dst[23]}}, x_dst};
			end
			ST_DET: begin
				if (ph_q == 2'd1) begin
					det_q  <= det_c;
					prod_q <= 39'(det_c) * signed'({1'b0, gain});
					big_q  <= mag_c > signed'({15'd0, cut_q});
				end else if (ph_q == 2'd2)
					nsrc_q <= nsrc_c;
			end
			default: ;
		endcase
		if (pend_q) begin
			out_pix_q  <= drain_pix;
			out_last_q <= (rp_q + 1'b1) >= size_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_LOAD;
			ph_q    <= 2'd0;
			wp_q    <= '0;
			rp_q    <= '0;
			size_q  <= '0;
			w_q     <= '0;
			h_q     <= '0;
			mind_q  <= '0;
			lvls_q  <= '0;
			lev_q   <= '0;
			hp_q    <= wls_pkg::PLANE_ACC;
			lp_q    <= wls_pkg::PLANE_A;
			ran_q   <= 1'b0;
			r_q     <= '0;
			c_q     <= '0;
			base_q  <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rsp.ready)
				out_v_q <= 1'b0;
			unique case (st_q)
				ST_LOAD: begin
					if (acc_in && !req.req_type) begin
						wp_q <= wp_nxt;
						if (wp_nxt >= size_live) begin
							w_q    <= ew;
							h_q    <= eh;
							size_q <= size_live;
							mind_q <= (ew < eh) ? ew : eh;
							lvls_q <= ({1'b0, lc_q} > MAX_LEVELS) ? LB'(MAX_LEVELS) : LB'(lc_q);
							lev_q  <= '0;
							hp_q   <= wls_pkg::PLANE_ACC;
							ran_q  <= 1'b0;
							st_q   <= ST_LEVEL;
						end
					end
				end
				ST_LEVEL: begin
					ph_q <= 2'd0;
					if ((lev_q < lvls_q) && ({1'b0, dil, 1'b0} < {2'b0, mind_q})) begin
						lp_q   <= lev_q[0] ? wls_pkg::PLANE_B : wls_pkg::PLANE_A;
						r_q    <= '0;
						c_q    <= '0;
						base_q <= '0;
						st_q   <= ST_HOR;
					end else if (ran_q) begin
						idx_q <= '0;
						st_q  <= ST_FIN;
					end else begin
						rp_q <= '0;
						st_q <= ST_DRAIN;
					end
				end
				ST_HOR, ST_VER: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (!col_last)
							c_q <= c_q + 12'd1;
						else begin
							c_q <= '0;
							if (!row_last) begin
								r_q    <= r_q + 12'd1;
								base_q <= base_q + AB'(w_q);
							end else begin
								r_q    <= '0;
								base_q <= '0;
								idx_q  <= '0;
								st_q   <= (st_q == ST_HOR) ? ST_VER : ST_DET;
							end
						end
					end
				end
				ST_DET: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (!idx_last)
							idx_q <= idx_q + 1'b1;
						else begin
							hp_q  <= lp_q;
							ran_q <= 1'b1;
							lev_q <= lev_q + 1'b1;
							st_q  <= ST_LEVEL;
						end
					end
				end
				ST_FIN: begin
					ph_q <= (ph_q == 2'd0) ? 2'd1 : 2'd0;
					if (ph_q == 2'd1) begin
						if (!idx_last)
							idx_q <= idx_q + 1'b1;
						else begin
							rp_q <= '0;
							st_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (acc_in && req.req_type)
						pend_q <= 1'b1;
					if (pend_q) begin
						pend_q  <= 1'b0;
						out_v_q <= 1'b1;
						if ((rp_q + 1'b1) >= size_q) begin
							rp_q <= '0;
							wp_q <= '0;
							st_q <= ST_LOAD;
						end else
							rp_q <= rp_q + 1'b1;
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	// checks
	`WLS_ASSERT_IMPLY(a_pend_in_drain, pend_q, st_q == ST_DRAIN, "read pending outside drain")
	`WLS_ASSERT_NEXT(a_read_starts, acc_in && req.req_type && (st_q == ST_DRAIN), pend_q, "drain read lost")
	`WLS_ASSERT_IMPLY(a_busy_blocks, (st_q != ST_LOAD) && (st_q != ST_DRAIN), !req.ready, "ready while processing")
	`WLS_ASSERT_NEXT(a_result_follows, pend_q, out_v_q, "drain result not registered")

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the wavelet luma sharpener: frames in, sharpened pixels checked.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int DEPTH = 1024 * 1024;

	// Expected drain pixel, oldest first
	typedef struct {
		logic [7:0] pix;
		logic       last;
	} drain_pix_t;

	// Scoreboard: own copy of registers, planes and positions; predicts each drain pixel
	class luma_scoreboard;
		int unsigned width_r, height_r, levels_r, cutoff_r;
		logic [38:0] gain_lo_r;
		logic [25:0] gain_hi_r;
		bit          ltd_r;
		int          planes[];     // accum, lowpass A, lowpass B back to back
		int          scratch[];
		int unsigned wr_pos, rd_pos, frame_px;
		bit          frame_done;
		drain_pix_t  pending[$];
		int          errors;

		function new();
			planes     = new[3 * DEPTH];
			scratch    = new[DEPTH];
			width_r    = 1024;
			height_r   = 1024;
			levels_r   = 3;
			cutoff_r   = 0;
			gain_lo_r  = 39'd17182066592;
			gain_hi_r  = 26'd2097408;
			ltd_r      = 0;
			wr_pos     = 0;
			rd_pos     = 0;
			frame_px   = 0;
			frame_done = 0;
			errors     = 0;
		endfunction

		function void cfg_write(logic [2:0] idx, logic [38:0] val);
			case (idx)
				wls_pkg::CFG_WIDTH:  width_r   = 32'(val[10:0]);
				wls_pkg::CFG_HEIGHT: height_r  = 32'(val[10:0]);
				wls_pkg::CFG_LEVELS: levels_r  = 32'(val[2:0]);
				wls_pkg::CFG_CUTOFF: cutoff_r  = 32'(val[9:0]);
				wls_pkg::CFG_GAIN_L: gain_lo_r = val;
				wls_pkg::CFG_GAIN_H: gain_hi_r = val[25:0];
				wls_pkg::CFG_RANGE:  ltd_r     = val[0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_w();
			return (width_r < 1) ? 1 : (width_r > 1024) ? 1024 : width_r;
		endfunction

		function int unsigned eff_h();
			return (height_r < 1) ? 1 : (height_r > 1024) ? 1024 : height_r;
		endfunction

		function int clip24(longint v);
			if (v > 64'sd8388607)
				return 8388607;
			if (v < -64'sd8388608)
				return -8388608;
			return int'(v);
		endfunction

		// Mirrored taps at distance d around k on a line of n
		function void taps(int unsigned k, int unsigned n, int unsigned d,
				output int unsigned lo, output int unsigned hi);
			if (k < d) begin
				lo = d - k;
				hi = k + d;
			end else if (k + d < n) begin
				lo = k - d;
				hi = k + d;
			end else begin
				lo = k - d;
				hi = 2 * n - 2 - (k + d);
			end
		endfunction

		function longint level_gain(int unsigned lev);
			if (lev < 3)
				return longint'((gain_lo_r >> (13 * lev)) & 39'h1FFF);
			if (lev < 5)
				return longint'((gain_hi_r >> (13 * (lev - 3))) & 26'h1FFF);
			return 256;
		endfunction

		// Full a-trous decomposition and recombination, run on the completing write
		function void sharpen_frame();
			int unsigned w, h, size, min_side, lv, hp, lp, d, src, dst, lo, hi;
			longint v, det, mag, g;
			bit ran;
			w = eff_w();
			h = eff_h();
			size = w * h;
			min_side = (w < h) ? w : h;
			lv = (levels_r > 5) ? 5 : levels_r;
			hp = 0;
			lp = 0;
			ran = 0;
			for (int unsigned lev = 0; lev < lv; lev++) begin
				d = 1 << lev;
				if (2 * d >= min_side)
					break;
				lp = (lev & 1) + 1;
				src = hp * DEPTH;
				dst = lp * DEPTH;
				for (int unsigned r = 0; r < h; r++)
					for (int unsigned c = 0; c < w; c++) begin
						taps(c, w, d, lo, hi);
						v = 2 * longint'(planes[src + r*w + c]) + planes[src + r*w + lo]
							+ planes[src + r*w + hi];
						planes[dst + r*w + c] = clip24(v);
					end
				for (int unsigned r = 0; r < h; r++) begin
					taps(r, h, d, lo, hi);
					for (int unsigned c = 0; c < w; c++) begin
						v = 2 * longint'(planes[dst + r*w + c]) + planes[dst + lo*w + c]
							+ planes[dst + hi*w + c];
						scratch[r*w + c] = clip24(v >>> 4);
					end
				end
				for (int unsigned i = 0; i < size; i++)
					planes[dst + i] = scratch[i];
				g = level_gain(lev);
				for (int unsigned i = 0; i < size; i++) begin
					det = longint'(planes[src + i]) - planes[dst + i];
					mag = (det < 0) ? -det : det;
					if (mag > longint'(cutoff_r))
						det = (det * g) >>> 8;
					planes[src + i] = clip24(det);
					if (hp != 0)
						planes[i] = clip24(longint'(planes[i]) + planes[src + i]);
				end
				hp = lp;
				ran = 1;
			end
			if (ran)
				for (int unsigned i = 0; i < size; i++)
					planes[i] = clip24(longint'(planes[i]) + planes[lp*DEPTH + i]);
			frame_px = size;
			frame_done = 1;
			rd_pos = 0;
		endfunction

		// Accepted request transfer
		function void note_request(logic rt, logic [7:0] px);
			int unsigned size;
			int lo_lim, hi_lim;
			longint v;
			drain_pix_t e;
			if (rt == 1'b0) begin
				if (frame_done)
					return;
				size = eff_w() * eff_h();
				if (wr_pos < size) begin
					planes[wr_pos] = int'(px) << 8;
					wr_pos++;
				end
				if (wr_pos >= size)
					sharpen_frame();
			end else begin
				if (!frame_done || rd_pos >= frame_px)
					return;
				lo_lim = ltd_r ? 16 : 0;
				hi_lim = ltd_r ? 235 : 255;
				v = longint'(planes[rd_pos]) >>> 8;
				if (v < lo_lim)
					v = lo_lim;
				if (v > hi_lim)
					v = hi_lim;
				e.pix = v[7:0];
				e.last = (rd_pos + 1 >= frame_px);
				pending.push_back(e);
				rd_pos++;
				if (e.last) begin
					frame_done = 0;
					wr_pos = 0;
					rd_pos = 0;
				end
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		// Accepted result transfer
		task check_pixel(logic [7:0] px, logic last);
			drain_pix_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected pixel %0d", px));
				return;
			end
			e = pending.pop_front();
			if (px !== e.pix)
				report($sformatf("out_pixel %0d, expected %0d", px, e.pix));
			if (last !== e.last)
				report($sformatf("last_of_frame %0b, expected %0b", last, e.last));
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [2:0]                     cfg_index;
	logic [wls_pkg::CFG_DATA_W-1:0] cfg_wdata;

	wls_req_if req ();
	wls_pix_if rsp ();

	wavelet_luma_sharpener u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	luma_scoreboard sb = new();

	int unsigned tx_idle;   // sender idle percentage
	int unsigned rx_idle;   // receiver idle percentage
	bit          hold_req;  // ask the receiver for one long stall
	int unsigned hold_cnt;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Generous cap; the slowest correct run is well under a tenth of this
	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off on request so the
	// output register fills and the read side of req stalls
	initial begin
		rsp.ready <= 1'b0;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp.ready <= 1'b0;
			end else if (hold_req && rsp.valid) begin
				hold_req = 0;
				hold_cnt = 400;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// Both channels sampled on the edge, before any drive of this step lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request(req.req_type, req.in_pixel);
			if (rsp.valid && rsp.ready)
				sb.check_pixel(rsp.out_pixel, rsp.last_of_frame);
		end
	end

	// One request transfer; valid stays high on return, caller lowers it when done
	task send_req(logic rt, logic [7:0] px);
		while ($urandom_range(99) < tx_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.req_type <= rt;
		req.in_pixel <= px;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	task cfg_put(logic [2:0] idx, logic [38:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.cfg_write(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until nothing is outstanding, then let the last dropped transfer clear
	task wait_quiet();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function logic [7:0] pick_pixel();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function logic [12:0] pick_gain();
		case ($urandom_range(4))
			0: return 13'd0;
			1: return wls_pkg::GAIN_UNITY;
			2: return 13'h1FFF;
			default: return 13'($urandom_range(1024));
		endcase
	endfunction

	// Load one frame, then drain it; noise_pct sprinkles reads into the load and
	// writes into the drain, both of which the block must drop
	task run_frame(int unsigned noise_pct);
		int unsigned size;
		size = sb.eff_w() * sb.eff_h();
		for (int unsigned i = 0; i < size; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_req(1'b1, pick_pixel());
			send_req(1'b0, pick_pixel());
		end
		for (int unsigned i = 0; i < size; i++) begin
			if (i > 0 && $urandom_range(99) < noise_pct)
				send_req(1'b0, pick_pixel());
			send_req(1'b1, pick_pixel());
		end
		req.valid <= 1'b0;
		wait_quiet();
	endtask

	task random_setting(int unsigned w, int unsigned h);
		cfg_put(wls_pkg::CFG_WIDTH, 39'(w));
		cfg_put(wls_pkg::CFG_HEIGHT, 39'(h));
		cfg_put(wls_pkg::CFG_LEVELS, 39'($urandom_range(7)));
		case ($urandom_range(3))
			0: cfg_put(wls_pkg::CFG_CUTOFF, 39'd0);
			1: cfg_put(wls_pkg::CFG_CUTOFF, 39'd1000);
			2: cfg_put(wls_pkg::CFG_CUTOFF, 39'd1023);
			default: cfg_put(wls_pkg::CFG_CUTOFF, 39'($urandom_range(300)));
		endcase
		cfg_put(wls_pkg::CFG_GAIN_L, {pick_gain(), pick_gain(), pick_gain()});
		cfg_put(wls_pkg::CFG_GAIN_H, 39'({pick_gain(), pick_gain()}));
		cfg_put(wls_pkg::CFG_RANGE, 39'($urandom_range(1)));
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= wls_pkg::CFG_WIDTH;
		cfg_wdata    <= '0;
		req.valid    <= 1'b0;
		req.req_type <= 1'b0;
		req.in_pixel <= 8'd0;
		tx_idle  = 28;
		rx_idle  = 55;
		hold_req = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a read before anything is loaded, then a 3x3 single-level frame
		send_req(1'b1, 8'hA5);
		req.valid <= 1'b0;
		wait_quiet();
		cfg_put(wls_pkg::CFG_WIDTH, 39'd3);
		cfg_put(wls_pkg::CFG_HEIGHT, 39'd3);
		cfg_put(wls_pkg::CFG_LEVELS, 39'd1);
		cfg_put(wls_pkg::CFG_CUTOFF, 39'd0);
		cfg_put(wls_pkg::CFG_GAIN_L, {3{13'h1FFF}});
		cfg_put(wls_pkg::CFG_GAIN_H, 39'({2{wls_pkg::GAIN_UNITY}}));
		cfg_put(wls_pkg::CFG_RANGE, 39'd1);
		run_frame(30);

		// Random frames, small sides, through the three idling phases
		for (int f = 0; f < 8; f++) begin
			if (f == 3) begin
				tx_idle = 55;
				rx_idle = 28;
			end else if (f == 6) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			random_setting($urandom_range(8), $urandom_range(8));
			if (f == 1)
				hold_req = 1;
			run_frame(10);
		end

		// Side large enough for all five levels, level count past the maximum
		random_setting(33, 33);
		cfg_put(wls_pkg::CFG_LEVELS, 39'd7);
		hold_req = 1;
		run_frame(2);

		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
